>>> rtl/paged_framebuffer_rect_draw_top_assert.svh
// Assertion macros for the framebuffer draw engine checker.
// Included by the checker file only; no other dependencies.
`ifndef PAGED_FRAMEBUFFER_RECT_DRAW_TOP_ASSERT_SVH
`define PAGED_FRAMEBUFFER_RECT_DRAW_TOP_ASSERT_SVH

// Clocked assertion, quiet while reset is applied.
`define PFRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PFRD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pfrd_pkg.sv
// Shared constants, types and opcodes of the framebuffer draw engine.
// No dependencies; imported by the controller, datapath and top level.
package pfrd_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_PAGES  = 8;
    localparam int SCREEN_HEIGHT = SCREEN_PAGES * 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W        = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    // wide enough to hold both a read index and the store size
    localparam int CMP_W         = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [PAGE_W-1:0] page_t;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_PIXEL     = 3'd1,
        OP_RECT_FILL = 3'd2,
        OP_RECT_LINE = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAW,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the command beat
        logic init_full;   // sweep over the whole store
        logic init_point;  // sweep over the single pixel byte
        logic advance;     // step the sweep counters
        logic mem_rd;      // read current byte for read-modify-write
        logic rd_index;    // read the byte named by read_index
        logic wr_fill;     // write fill data at current byte
        logic wr_zero;     // fill data is zero (reset clearing)
        logic out_load;    // load the response register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;        // current byte is the last of the sweep
        logic out_free;    // response register can take a beat
    } dp_status_t;

endpackage

>>> rtl/pfrd_cmd_if.sv
// Command channel: valid/ready handshake with the draw command payload.
// No dependencies.
interface pfrd_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       color;
    logic [7:0] fill_byte;
    logic [9:0] read_index;

    modport source (output valid, op, x, y, w, h, color, fill_byte, read_index,
                    input ready);
    modport sink   (input valid, op, x, y, w, h, color, fill_byte, read_index,
                    output ready);
endinterface

>>> rtl/pfrd_rsp_if.sv
// Response channel: valid/ready handshake with status and read data.
// No dependencies.
interface pfrd_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_data;

    modport source (output valid, status, read_data, input ready);
    modport sink   (input valid, status, read_data, output ready);
endinterface

>>> rtl/pfrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pfrd_ctrl.sv
// Command sequencer of the draw engine: clearing pass, fills, RMW sweeps.
// Depends on pfrd_pkg.
module pfrd_ctrl import pfrd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_op,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_fill = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.advance = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_op) inside
                        OP_CLEAR:
                        begin
                            cmd.init_full = 1'b1;
                            state_next    = ST_FILL;
                        end
                        OP_PIXEL:
                        begin
                            cmd.init_point = 1'b1;
                            state_next     = ST_DRAW;
                        end
                        OP_RECT_FILL, OP_RECT_LINE:
                        begin
                            cmd.init_full = 1'b1;
                            state_next    = ST_DRAW;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.wr_fill = 1'b1;
                cmd.advance = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DRAW:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.advance = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last write-back of the sweep lands here
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                cmd.rd_index = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pfrd_dp.sv
// Datapath of the draw engine: sweep counters, per-byte pixel mask,
// read-modify-write merge, frame store and response register.
// Depends on pfrd_pkg and pfrd_ram.
module pfrd_dp import pfrd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_cmd_t   cmd,
    output dp_status_t stat,
    input  logic [2:0] in_op,
    input  logic [7:0] in_x,
    input  logic [7:0] in_y,
    input  logic [7:0] in_w,
    input  logic [7:0] in_h,
    input  logic       in_color,
    input  logic [7:0] in_fill_byte,
    input  logic [9:0] in_read_index,
    input  logic       rsp_ready,
    output logic       rsp_valid,
    output logic       rsp_status,
    output logic [7:0] rsp_read_data
);

    // captured command
    logic [2:0] op_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] w_reg;
    logic [7:0] h_reg;
    logic       color_reg;
    logic [7:0] fill_reg;
    logic [9:0] ridx_reg;
    logic       on_screen_reg;
    logic       ridx_ok_reg;

    // sweep position
    addr_t addr_reg;
    addr_t last_reg;
    col_t  col_reg;
    page_t page_reg;

    // write-back stage
    logic       wb_valid_reg;
    addr_t      wb_addr_reg;
    logic [7:0] wb_mask_reg;

    // response register
    logic       out_valid_reg;
    logic       out_status_reg;
    logic [7:0] out_data_reg;

    logic       in_on_screen;
    addr_t      in_pixel_addr;
    logic [7:0] mask;
    logic [7:0] ram_rdata;
    logic [7:0] merged;
    logic       ram_we;
    addr_t      ram_waddr;
    logic [7:0] ram_wdata;
    logic       ram_re;
    addr_t      ram_raddr;

    assign in_on_screen  = ({1'b0, in_x} < 9'(SCREEN_WIDTH)) &&
                           ({1'b0, in_y} < 9'(SCREEN_HEIGHT));
    assign in_pixel_addr = addr_t'(in_x) + addr_t'(in_y[7:3]) * addr_t'(SCREEN_WIDTH);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= in_op;
            x_reg         <= in_x;
            y_reg         <= in_y;
            w_reg         <= in_w;
            h_reg         <= in_h;
            color_reg     <= in_color;
            fill_reg      <= in_fill_byte;
            ridx_reg      <= in_read_index;
            on_screen_reg <= in_on_screen;
            ridx_ok_reg   <= CMP_W'(in_read_index) < CMP_W'(STORE_BYTES);
        end
    end

    // sweep counters; reset values start the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            last_reg <= addr_t'(STORE_BYTES - 1);
            col_reg  <= '0;
            page_reg <= '0;
        end
        else if (cmd.init_full || (cmd.init_point && !in_on_screen))
        begin
            addr_reg <= '0;
            last_reg <= cmd.init_full ? addr_t'(STORE_BYTES - 1) : '0;
            col_reg  <= '0;
            page_reg <= '0;
        end
        else if (cmd.init_point)
        begin
            addr_reg <= in_pixel_addr;
            last_reg <= in_pixel_addr;
            col_reg  <= col_t'(in_x);
            page_reg <= page_t'(in_y[7:3]);
        end
        else if (cmd.advance)
        begin
            addr_reg <= addr_reg + addr_t'(1);
            if (col_reg == col_t'(SCREEN_WIDTH - 1))
            begin
                col_reg  <= '0;
                page_reg <= page_reg + page_t'(1);
            end
            else
            begin
                col_reg <= col_reg + col_t'(1);
            end
        end
    end

    // pixel mask of the current byte: distances wrap mod 256
    always_comb
    begin
        logic [7:0] cd;
        logic [7:0] rd;
        logic [7:0] wm1;
        logic [7:0] hm1;
        cd  = 8'(col_reg) - x_reg;
        wm1 = w_reg - 8'd1;
        hm1 = h_reg - 8'd1;
        mask = '0;
        for (int k = 0; k < 8; k++)
        begin
            rd = 8'({page_reg, 3'b000}) + 8'(k) - y_reg;
            unique case (op_reg)
                OP_PIXEL:
                    mask[k] = on_screen_reg && (cd == 8'd0) && (rd == 8'd0);
                OP_RECT_FILL:
                    mask[k] = (cd < w_reg) && (rd < h_reg);
                OP_RECT_LINE:
                    mask[k] = ((cd < w_reg) && ((rd == 8'd0) || (rd == hm1))) ||
                              ((rd < h_reg) && ((cd == 8'd0) || (cd == wm1)));
                default:
                    mask[k] = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= cmd.mem_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            wb_addr_reg <= addr_reg;
            wb_mask_reg <= mask;
        end
    end

    assign merged    = color_reg ? (ram_rdata | wb_mask_reg) : (ram_rdata & ~wb_mask_reg);
    assign ram_we    = cmd.wr_fill || wb_valid_reg;
    assign ram_waddr = cmd.wr_fill ? addr_reg : wb_addr_reg;
    assign ram_wdata = cmd.wr_fill ? (cmd.wr_zero ? 8'd0 : fill_reg) : merged;
    assign ram_re    = cmd.mem_rd || (cmd.rd_index && ridx_ok_reg);
    assign ram_raddr = cmd.rd_index ? addr_t'(ridx_reg) : addr_reg;

    pfrd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= (op_reg == OP_PIXEL) && !on_screen_reg;
            out_data_reg   <= ((op_reg == OP_READ) && ridx_ok_reg) ? ram_rdata : 8'd0;
        end
    end

    assign stat.last      = (addr_reg == last_reg);
    assign stat.out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_read_data  = out_data_reg;

endmodule

>>> rtl/paged_framebuffer_rect_draw_top.sv
// Channel  Dir  Beat contents
// -------  ---  ----------------------------------------------------------
// cmd      in   op, x, y, w, h, color, fill_byte, read_index
// rsp      out  status, read_data (one beat per command beat)
//
// A clear fill or a rectangle sweeps every byte of the frame store, a pixel
// touches one byte; one frame store write port sets the pace
// (one read-modify-write per byte).
// After reset a clearing pass zeroes the store, with cmd.ready low.
// A command beat is taken while the previous response still waits; the
// new one then holds in its last cycle until the response register frees.
//
// Top level of the paged framebuffer draw engine.
// Depends on pfrd_pkg, pfrd_cmd_if, pfrd_rsp_if, pfrd_ctrl, pfrd_dp.
module paged_framebuffer_rect_draw_top import pfrd_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    pfrd_cmd_if.sink cmd,
    pfrd_rsp_if.source rsp
);

    ctl_cmd_t   ctl;
    dp_status_t stat;

    // Sequencer: owns cmd.ready; a command is taken only in idle, so one
    // command is in the engine at a time.
    pfrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_op    (cmd.op),
        .in_ready (cmd.ready),
        .stat     (stat),
        .cmd      (ctl)
    );

    // Datapath: sweeps every store byte for rectangles (mask decides which
    // bits change), a single byte for a pixel, and holds the response.
    pfrd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl),
        .stat          (stat),
        .in_op         (cmd.op),
        .in_x          (cmd.x),
        .in_y          (cmd.y),
        .in_w          (cmd.w),
        .in_h          (cmd.h),
        .in_color      (cmd.color),
        .in_fill_byte  (cmd.fill_byte),
        .in_read_index (cmd.read_index),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_read_data (rsp.read_data)
    );

endmodule

>>> rtl/pfrd_checker.sv
// Port-level checker for the draw engine, bound to the top level.
// Depends on paged_framebuffer_rect_draw_top_assert.svh.
`include "paged_framebuffer_rect_draw_top_assert.svh"

module pfrd_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic rsp_valid,
    input logic rsp_ready
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       cmd_beat;
    logic       rsp_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_beat && !rsp_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_beat && !cmd_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // one command in the engine at a time
    `PFRD_ASSERT(a_busy_after_take, clk, rst_n, cmd_beat |=> !cmd_ready, "ready after take")
    // store clearing keeps the command side closed through reset
    `PFRD_ASSERT_NR(a_closed_in_reset, clk, !rst_n |=> !cmd_ready, "ready during clear")
    `PFRD_ASSERT(a_rsp_has_cmd, clk, rst_n, rsp_valid |-> (pending_reg != 2'd0), "stray response")
    `PFRD_ASSERT(a_pending_bound, clk, rst_n, pending_reg != 2'd3, "too many pending")
    `PFRD_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

endmodule

bind paged_framebuffer_rect_draw_top pfrd_checker u_pfrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

>>> dv/pfrd_frame_checker.sv
// Checker for the framebuffer draw engine: keeps a copy of the frame store,
// predicts one reply per command beat, and compares the reply beats.
// Depends on pfrd_pkg, pfrd_cmd_if and pfrd_rsp_if.
module pfrd_frame_checker import pfrd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    pfrd_cmd_if  cmd,
    pfrd_rsp_if  rsp,
    output int   mismatch_count,
    output int   replies_outstanding,
    output int   replies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } reply_t;

    logic [7:0] frame_model [STORE_BYTES];
    reply_t     awaited_replies [$];

    // Coordinates arrive already truncated to 8 bits, so wrap is implicit.
    function automatic logic plot_pixel(input logic [7:0] px, input logic [7:0] py,
                                        input logic color);
        addr_t idx;
        if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return 1'b1;
        idx = addr_t'(px) + addr_t'(py >> 3) * addr_t'(SCREEN_WIDTH);
        frame_model[idx][py[2:0]] = color;
        return 1'b0;
    endfunction

    function automatic reply_t draw_into_frame_model(
        input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
        input logic [7:0] w, input logic [7:0] h, input logic color,
        input logic [7:0] fill, input logic [9:0] ridx);
        reply_t r;
        r = '0;
        case (op)
            OP_CLEAR:
                foreach (frame_model[k])
                    frame_model[k] = fill;
            OP_PIXEL:
                r.status = plot_pixel(x, y, color);
            OP_RECT_FILL:
                for (int i = 0; i < w; i++)
                    for (int j = 0; j < h; j++)
                        void'(plot_pixel(8'(x + i), 8'(y + j), color));
            OP_RECT_LINE:
            begin
                // far edges at y+h-1 and x+w-1, mod 256 by truncation
                for (int i = 0; i < w; i++)
                begin
                    void'(plot_pixel(8'(x + i), y, color));
                    void'(plot_pixel(8'(x + i), 8'(y + h - 1), color));
                end
                for (int i = 0; i < h; i++)
                begin
                    void'(plot_pixel(x, 8'(y + i), color));
                    void'(plot_pixel(8'(x + w - 1), 8'(y + i), color));
                end
            end
            OP_READ:
                if (ridx < STORE_BYTES)
                    r.read_data = frame_model[ridx];
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        reply_t want;
        if (!rst_n)
        begin
            foreach (frame_model[k])
                frame_model[k] = '0;
            awaited_replies.delete();
            mismatch_count      = 0;
            replies_checked     = 0;
            replies_outstanding <= 0;
        end
        else
        begin
            // reply first: a reply in the same cycle belongs to an older command
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("reply beat with no command waiting: status %0d read_data 0x%02h",
                           rsp.status, rsp.read_data);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    replies_checked++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected 0x%02h, got 0x%02h",
                               want.read_data, rsp.read_data);
                        mismatch_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                awaited_replies.push_back(draw_into_frame_model(
                    cmd.op, cmd.x, cmd.y, cmd.w, cmd.h, cmd.color,
                    cmd.fill_byte, cmd.read_index));
            replies_outstanding <= awaited_replies.size();
        end
    end

endmodule

>>> dv/tb_paged_framebuffer_rect_draw_top.sv
// Testbench top for the framebuffer draw engine: clock, reset, command
// stimulus and reply back-pressure; the checker does the prediction.
// Depends on pfrd_pkg, both channel interfaces, the DUT and pfrd_frame_checker.
module tb_paged_framebuffer_rect_draw_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pfrd_pkg::*;

    // Timeout: the slowest legal run, taken several times over.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 555;
    localparam int PHASE_ITEMS  = 60;
    localparam int GAP_MAX      = 10;
    // longest command is a rectangle sweep over the whole store
    localparam int TAIL_CYCLES  = STORE_BYTES + 64;

    // opcodes the block does not define; it must answer them with ok/zero
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;

    pfrd_cmd_if cmd_ch ();
    pfrd_rsp_if rsp_ch ();

    int mismatch_count;
    int replies_outstanding;
    int replies_checked;

    int cycle_count = 0;
    int reply_stall;
    bit cmd_steady;     // sender runs back-to-back when set
    bit rsp_steady;     // receiver never stalls when set

    int n_pixel, n_rect, n_read, n_clear, n_spare;
    logic [9:0] last_pixel_byte;

    paged_framebuffer_rect_draw_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    pfrd_frame_checker frame_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd_ch),
        .rsp                 (rsp_ch),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding),
        .replies_checked     (replies_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs somewhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies still awaited",
                     cycle_count, replies_outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Reply back-pressure: after each reply beat, hold ready low for a
    // freshly drawn random stall (none while rsp_steady is set).
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reply_stall <= 0;
        else if (rsp_ch.valid && rsp_ch.ready)
            reply_stall <= rsp_steady ? 0 : $urandom_range(0, GAP_MAX);
        else if (reply_stall != 0)
            reply_stall <= reply_stall - 1;
    end

    // reply ready: known from time zero, then updated at each falling edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= (reply_stall == 0);
        end
    end

    // One command beat. Valid is lowered only when a gap is drawn, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    // Returns at the rising edge that took the beat.
    task automatic send_command(input logic [2:0] op, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] w,
                                input logic [7:0] h, input logic color,
                                input logic [7:0] fill, input logic [9:0] ridx);
        int gap;
        gap = cmd_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.op         <= op;
        cmd_ch.x          <= x;
        cmd_ch.y          <= y;
        cmd_ch.w          <= w;
        cmd_ch.h          <= h;
        cmd_ch.color      <= color;
        cmd_ch.fill_byte  <= fill;
        cmd_ch.read_index <= ridx;
        cmd_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        case (op) inside
            OP_PIXEL:                  n_pixel++;
            OP_RECT_FILL, OP_RECT_LINE: n_rect++;
            OP_READ:                   n_read++;
            OP_CLEAR:                  n_clear++;
            default:                   n_spare++;
        endcase
    endtask

    // Stop sending until every reply is back (block goes fully idle).
    task automatic wait_replies_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (replies_outstanding != 0)
            @(negedge clk);
    endtask

    // Random command. All fields are random on every beat; coordinates lean
    // on-screen and sizes lean small so the sweeps stay short, with the full
    // 8-bit range mixed in. Reads often target the last pixel drawn.
    task automatic send_random_command();
        int pick;
        logic [2:0] op;
        logic [7:0] x, y, w, h, fill;
        logic       color;
        logic [9:0] ridx;
        pick  = $urandom_range(0, 99);
        x     = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, SCREEN_WIDTH + 8)
                                               : $urandom_range(0, 255));
        y     = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, SCREEN_HEIGHT + 8)
                                               : $urandom_range(0, 255));
        w     = 8'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 20)
                                               : $urandom_range(0, 255));
        h     = 8'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 20)
                                               : $urandom_range(0, 255));
        color = ($urandom_range(0, 3) != 0);
        fill  = 8'($urandom_range(0, 255));
        ridx  = 10'($urandom_range(0, STORE_BYTES - 1));
        if (pick < 4)
            op = OP_CLEAR;
        else if (pick < 7)
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (pick < 40)
        begin
            op    = OP_PIXEL;
            color = 1'($urandom_range(0, 1));
            if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT)
                last_pixel_byte = 10'(int'(x) + int'(y >> 3) * SCREEN_WIDTH);
        end
        else if (pick < 50)
            op = OP_RECT_FILL;
        else if (pick < 60)
            op = OP_RECT_LINE;
        else
        begin
            op = OP_READ;
            if ($urandom_range(0, 1) != 0)
                ridx = last_pixel_byte;
        end
        send_command(op, x, y, w, h, color, fill, ridx);
    endtask

    initial
    begin
        // every block input known from time zero
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_CLEAR;
        cmd_ch.x          = '0;
        cmd_ch.y          = '0;
        cmd_ch.w          = '0;
        cmd_ch.h          = '0;
        cmd_ch.color      = 1'b0;
        cmd_ch.fill_byte  = '0;
        cmd_ch.read_index = '0;
        cmd_steady        = 1'b0;
        rsp_steady        = 1'b0;
        last_pixel_byte   = '0;
        n_pixel = 0; n_rect = 0; n_read = 0; n_clear = 0; n_spare = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the post-reset clearing pass holds cmd.ready low; the handshake waits

        // ---- directed ----
        // store starts cleared
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 0);
        // full fill, then clear the bottom-right pixel (last byte, top bit)
        send_command(OP_CLEAR, 0, 0, 0, 0, 0, 8'hFF, 0);
        send_command(OP_PIXEL, 8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1), 0, 0, 0,
                     8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(STORE_BYTES - 1));
        // pixels just off the right edge, bottom edge, and at max coordinates
        send_command(OP_PIXEL, 8'(SCREEN_WIDTH), 0, 0, 0, 1, 8'h00, 0);
        send_command(OP_PIXEL, 0, 8'(SCREEN_HEIGHT), 0, 0, 1, 8'h00, 0);
        send_command(OP_PIXEL, 255, 255, 255, 255, 1, 8'hFF, 10'h3FF);
        send_command(OP_CLEAR, 0, 0, 0, 0, 0, 8'h00, 0);
        // filled rectangle wrapping in x and clipped in y
        send_command(OP_RECT_FILL, 250, 60, 20, 10, 1, 8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(7 * SCREEN_WIDTH));
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(7 * SCREEN_WIDTH + 13));
        // outline with zero width: vertical edges at columns x and x-1
        send_command(OP_RECT_LINE, 10, 8, 0, 5, 1, 8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(SCREEN_WIDTH + 10));
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(SCREEN_WIDTH + 9));
        // outline with zero height: horizontal edges at rows y and y-1
        send_command(OP_RECT_LINE, 20, 16, 4, 0, 1, 8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(2 * SCREEN_WIDTH + 20));
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(SCREEN_WIDTH + 20));
        // maximum rectangle set, then maximum outline cleared
        send_command(OP_RECT_FILL, 0, 0, 255, 255, 1, 8'h00, 0);
        send_command(OP_RECT_LINE, 0, 0, 255, 255, 0, 8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 10'(STORE_BYTES - 1));
        // undefined opcodes change nothing
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_command(3'(op), 5, 5, 5, 5, 1, 8'h5A, 10'h155);
        send_command(OP_CLEAR, 0, 0, 0, 0, 0, 8'hA5, 0);
        send_command(OP_READ, 0, 0, 0, 0, 0, 8'h00, 300);

        // ---- random ----
        // Phases switch the idling style; each phase boundary drains replies
        // first, so the sender regularly pauses with the block fully idle.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                wait_replies_drained();
                cmd_steady = ($urandom_range(0, 3) == 0);
                rsp_steady = ($urandom_range(0, 3) == 0);
            end
            send_random_command();
        end

        // ---- wind down ----
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (replies_outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d pixel, %0d rectangle, %0d read, %0d fill, %0d spare",
                 n_pixel + n_rect + n_read + n_clear + n_spare,
                 n_pixel, n_rect, n_read, n_clear, n_spare);
        $display("Compared %0d reply beats against the frame model in %0d cycles",
                 replies_checked, cycle_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> paged_framebuffer_rect_draw_top.f
+incdir+rtl
rtl/pfrd_pkg.sv
rtl/pfrd_cmd_if.sv
rtl/pfrd_rsp_if.sv
rtl/pfrd_ram.sv
rtl/pfrd_ctrl.sv
rtl/pfrd_dp.sv
rtl/paged_framebuffer_rect_draw_top.sv
rtl/pfrd_checker.sv
dv/pfrd_frame_checker.sv
dv/tb_paged_framebuffer_rect_draw_top.sv
